>>> rtl/core/smrb_pkg.sv
package smrb_pkg;

	// One bus access as it arrives on the request side.
	typedef struct packed {
		logic        op;
		logic [4:0]  reg_req;
		logic [31:0] wdata;
		logic [31:0] miso_word;
	} smrb_req_t;

	// One access result as it leaves on the response side.
	typedef struct packed {
		logic [31:0] rdata;
		logic [31:0] mosi_word;
		logic [2:0]  mosi_bytes;
		logic        irq;
		logic        bad_access;
	} smrb_rsp_t;

	// The receive count field is five bits wide, enough for a FIFO of up to 31 words.
	localparam int FIFO_CNT_W = 5;

	// Commands from the register logic to the receive FIFO.
	typedef struct packed {
		logic        push;
		logic        pop;
		logic        flush;
		logic [31:0] wdata;
	} smrb_fifo_ctrl_t;

	// FIFO fill level and oldest word, back to the register logic.
	typedef struct packed {
		logic [FIFO_CNT_W-1:0] count;
		logic [31:0]           head;
	} smrb_fifo_stat_t;

	// Access direction codes.
	localparam logic OP_READ  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	// Register word indexes.
	localparam logic [4:0] REG_VERID = 5'd0;
	localparam logic [4:0] REG_PARAM = 5'd1;
	localparam logic [4:0] REG_MCFG  = 5'd2;
	localparam logic [4:0] REG_MODE  = 5'd3;
	localparam logic [4:0] REG_CR    = 5'd4;
	localparam logic [4:0] REG_SR    = 5'd5;
	localparam logic [4:0] REG_IER   = 5'd6;
	localparam logic [4:0] REG_DER   = 5'd7;
	localparam logic [4:0] REG_CFGR0 = 5'd8;
	localparam logic [4:0] REG_CFGR1 = 5'd9;
	localparam logic [4:0] REG_CCR   = 5'd16;
	localparam logic [4:0] REG_FCR   = 5'd22;
	localparam logic [4:0] REG_FSR   = 5'd23;
	localparam logic [4:0] REG_TCR   = 5'd24;
	localparam logic [4:0] REG_TDR   = 5'd25;
	localparam logic [4:0] REG_RSR   = 5'd28;
	localparam logic [4:0] REG_RDR   = 5'd29;

	// Fixed register values and masks.
	localparam logic [31:0] VERID_VALUE = 32'h0104_0004;
	localparam logic [31:0] FCR_MASK    = 32'h001f_001f;
	localparam logic [31:0] RSR_RXEMPTY = 32'h0000_0002;
	localparam logic [7:0]  PCSNUM      = 8'd4;

	// Control register bits.
	localparam int CR_MEN = 0;
	localparam int CR_RST = 1;
	localparam int CR_RRF = 9;
	localparam logic [31:0] CR_NOSTORE = 32'h0000_0302;

	// Status register bits.
	localparam int SR_TDF = 0;
	localparam int SR_RDF = 1;
	localparam int SR_TCF = 10;
	localparam int SR_TEF = 11;
	localparam int SR_MBF = 24;
	localparam logic [31:0] SR_W1C      = 32'h0000_3f00;
	localparam logic [31:0] SR_IRQ_MASK = 32'h0000_0803;
	localparam logic [31:0] SR_RESET    = 32'h0000_0001;

	// Transmit command register fields.
	localparam int TCR_TX_ONES = 18;
	localparam int TCR_RX_OFF  = 19;
	localparam logic [31:0] TCR_RESET = 32'd31;

endpackage

>>> rtl/core/spi_master_register_block.sv
// Channel    Ports                 Beat taken when
// --------   -------------------   ------------------------------
// request    start, busy, req      start high and busy low
// response   done, rsp             done high
//
// One access is taken every cycle; busy stays low.
// Each result passes through the input register and then the result register,
// with the state updated in between.
// arst_n clears the control and state registers but not the data registers; the receive FIFO comes up empty.
// The receiver cannot stall: there is no ready input on the response side.
module spi_master_register_block
	import smrb_pkg::*;
#(
	parameter int RX_DEPTH = 4
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  smrb_req_t req,
	output logic      done,
	output smrb_rsp_t rsp
);

	logic            valid_s1;
	smrb_req_t       req_s1;
	smrb_rsp_t       rsp_d;
	smrb_rsp_t       rsp_q;
	logic            done_q;
	smrb_fifo_ctrl_t fifo_ctrl;
	smrb_fifo_stat_t fifo_stat;

	assign busy = 1'b0;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			req_s1 <= req;
		end
	end

	// Register file and access decode.
	smrb_regs #(
		.RX_DEPTH (RX_DEPTH)
	) u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.req_s1    (req_s1),
		.fifo_stat (fifo_stat),
		.fifo_ctrl (fifo_ctrl),
		.rsp       (rsp_d)
	);

	// Receive FIFO.
	smrb_rx_fifo #(
		.RX_DEPTH (RX_DEPTH)
	) u_rx_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (fifo_ctrl),
		.stat   (fifo_stat)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			rsp_q <= rsp_d;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

`ifndef ASSERT_OFF
	// Every access in the input register produces a result in the next cycle.
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |=> done)
		else $error("access in stage one produced no result");

	// The FIFO fill level never passes its depth.
	a_fifo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_stat.count <= FIFO_CNT_W'(RX_DEPTH))
		else $error("receive FIFO count above depth");

	// No bytes sent means an all-zero transmit word.
	a_idle_mosi: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.mosi_bytes == 3'd0) |-> rsp.mosi_word == 32'd0)
		else $error("transmit word set without a frame");

	// Push and pop never happen together.
	a_fifo_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(fifo_ctrl.push && fifo_ctrl.pop))
		else $error("receive FIFO push and pop in one cycle");
`endif

endmodule

>>> rtl/core/smrb_rx_fifo.sv
module smrb_rx_fifo
	import smrb_pkg::*;
#(
	parameter int RX_DEPTH = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  smrb_fifo_ctrl_t ctrl,
	output smrb_fifo_stat_t stat
);

	localparam int PTR_W = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RX_DEPTH - 1);

	logic [31:0]           mem_q [RX_DEPTH];
	logic [31:0]           head_q;
	logic [PTR_W-1:0]      rd_ptr_q;
	logic [PTR_W-1:0]      rd_ptr_nxt;
	logic [PTR_W-1:0]      wr_ptr_q;
	logic [FIFO_CNT_W-1:0] count_q;

	assign rd_ptr_nxt = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;

	// Word storage; entries are only read after they have been written.
	// The oldest word is kept in a register: a push into an empty FIFO loads it
	// directly, and a pop that leaves words behind loads the next one.
	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			mem_q[wr_ptr_q] <= ctrl.wdata;
			if (count_q == '0) begin
				head_q <= ctrl.wdata;
			end
		end else if (ctrl.pop && count_q > FIFO_CNT_W'(1)) begin
			head_q <= mem_q[rd_ptr_nxt];
		end
	end

	// Circular pointers and fill count; the register logic never pushes when full
	// nor pops when empty.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			count_q  <= '0;
		end else if (ctrl.flush) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			count_q  <= '0;
		end else if (ctrl.push) begin
			wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			count_q  <= count_q + 1'b1;
		end else if (ctrl.pop) begin
			rd_ptr_q <= rd_ptr_nxt;
			count_q  <= count_q - 1'b1;
		end
	end

	assign stat.count = count_q;
	assign stat.head  = head_q;

endmodule

>>> rtl/core/smrb_regs.sv
module smrb_regs
	import smrb_pkg::*;
#(
	parameter int RX_DEPTH = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            valid_s1,
	input  smrb_req_t       req_s1,
	input  smrb_fifo_stat_t fifo_stat,
	output smrb_fifo_ctrl_t fifo_ctrl,
	output smrb_rsp_t       rsp
);

	localparam int DEPTH_LOG2 = $clog2(RX_DEPTH + 1) - 1;
	localparam logic [31:0] PARAM_WORD = {8'd0, PCSNUM, 8'(DEPTH_LOG2), 8'(DEPTH_LOG2)};
	localparam logic [FIFO_CNT_W-1:0] CNT_DEPTH = FIFO_CNT_W'(RX_DEPTH);

	logic [31:0] cr_q, sr_q, ier_q, der_q, cfgr0_q, cfgr1_q;
	logic [31:0] ccr_q, fcr_q, tcr_q, mcfg_q, mode_q;
	logic [31:0] cr_d, sr_d, ier_d, der_d, cfgr0_d, cfgr1_d;
	logic [31:0] ccr_d, fcr_d, tcr_d, mcfg_d, mode_d;

	logic [11:0] frame_size;
	logic [4:0]  frame_round;
	logic [2:0]  frame_bytes;
	logic [31:0] frame_mask;
	logic [31:0] tx_word;

	// Frame length in whole bytes, capped at four.
	always_comb begin
		frame_size  = tcr_q[11:0];
		frame_round = frame_size[4:0] + 5'd8;
		if (frame_size >= 12'd24) begin
			frame_bytes = 3'd4;
		end else begin
			frame_bytes = 3'(frame_round >> 3);
		end
		case (frame_bytes)
			3'd1:    frame_mask = 32'h0000_00ff;
			3'd2:    frame_mask = 32'h0000_ffff;
			3'd3:    frame_mask = 32'h00ff_ffff;
			default: frame_mask = 32'hffff_ffff;
		endcase
		tx_word = tcr_q[TCR_TX_ONES] ? 32'hffff_ffff : req_s1.wdata;
	end

	// Register decode and next-state logic for the access held in stage one.
	always_comb begin
		cr_d    = cr_q;
		sr_d    = sr_q;
		ier_d   = ier_q;
		der_d   = der_q;
		cfgr0_d = cfgr0_q;
		cfgr1_d = cfgr1_q;
		ccr_d   = ccr_q;
		fcr_d   = fcr_q;
		tcr_d   = tcr_q;
		mcfg_d  = mcfg_q;
		mode_d  = mode_q;
		rsp     = '0;
		fifo_ctrl       = '0;
		fifo_ctrl.wdata = req_s1.miso_word & frame_mask;

		if (valid_s1) begin
			if (req_s1.op == OP_READ) begin
				case (req_s1.reg_req)
					REG_VERID: rsp.rdata = VERID_VALUE;
					REG_PARAM: rsp.rdata = PARAM_WORD;
					REG_MCFG:  rsp.rdata = mcfg_q;
					REG_MODE:  rsp.rdata = mode_q;
					REG_CR:    rsp.rdata = cr_q;
					REG_SR:    rsp.rdata = sr_q;
					REG_IER:   rsp.rdata = ier_q;
					REG_DER:   rsp.rdata = der_q;
					REG_CFGR0: rsp.rdata = cfgr0_q;
					REG_CFGR1: rsp.rdata = cfgr1_q;
					REG_CCR:   rsp.rdata = ccr_q;
					REG_FCR:   rsp.rdata = fcr_q;
					REG_FSR:   rsp.rdata = {11'd0, fifo_stat.count, 16'd0};
					REG_TCR:   rsp.rdata = tcr_q;
					REG_RSR:   rsp.rdata = (fifo_stat.count == '0) ? RSR_RXEMPTY : '0;
					REG_RDR: begin
						// A pop of an empty FIFO reads zero and changes nothing.
						if (fifo_stat.count != '0) begin
							rsp.rdata     = fifo_stat.head;
							fifo_ctrl.pop = 1'b1;
							if (fifo_stat.count == FIFO_CNT_W'(1)) begin
								sr_d[SR_RDF] = 1'b0;
							end
						end
					end
					default:   rsp.bad_access = 1'b1;
				endcase
			end else begin
				case (req_s1.reg_req)
					REG_MCFG:  mcfg_d  = req_s1.wdata;
					REG_MODE:  mode_d  = req_s1.wdata;
					REG_CR: begin
						if (req_s1.wdata[CR_RST]) begin
							// Software reset returns every register to its reset value.
							cr_d    = '0;
							sr_d    = SR_RESET;
							ier_d   = '0;
							der_d   = '0;
							cfgr0_d = '0;
							cfgr1_d = '0;
							ccr_d   = '0;
							fcr_d   = '0;
							tcr_d   = TCR_RESET;
							mcfg_d  = '0;
							mode_d  = '0;
							fifo_ctrl.flush = 1'b1;
						end else begin
							cr_d = req_s1.wdata & ~CR_NOSTORE;
							if (req_s1.wdata[CR_RRF]) begin
								fifo_ctrl.flush = 1'b1;
								sr_d[SR_RDF]    = 1'b0;
							end
						end
					end
					REG_SR:    sr_d    = sr_q & ~(req_s1.wdata & SR_W1C);
					REG_IER:   ier_d   = req_s1.wdata;
					REG_DER:   der_d   = req_s1.wdata;
					REG_CFGR0: cfgr0_d = req_s1.wdata;
					REG_CFGR1: cfgr1_d = req_s1.wdata;
					REG_CCR:   ccr_d   = req_s1.wdata;
					REG_FCR:   fcr_d   = req_s1.wdata & FCR_MASK;
					REG_TCR:   tcr_d   = req_s1.wdata;
					REG_TDR: begin
						if (!cr_q[CR_MEN]) begin
							// Module disabled: the frame is refused.
							sr_d[SR_TEF] = 1'b1;
						end else begin
							rsp.mosi_word  = tx_word & frame_mask;
							rsp.mosi_bytes = frame_bytes;
							sr_d[SR_MBF]   = 1'b0;
							sr_d[SR_TCF]   = 1'b1;
							sr_d[SR_TDF]   = 1'b1;
							if (!tcr_q[TCR_RX_OFF]) begin
								if (fifo_stat.count < CNT_DEPTH) begin
									fifo_ctrl.push = 1'b1;
									sr_d[SR_RDF]   = 1'b1;
								end else begin
									sr_d[SR_TEF] = 1'b1;
								end
							end
						end
					end
					REG_VERID, REG_PARAM, REG_FSR, REG_RSR, REG_RDR: begin
					end
					default:   rsp.bad_access = 1'b1;
				endcase
			end
		end

		rsp.irq = |(ier_d & sr_d & SR_IRQ_MASK);
	end

	// Register state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cr_q    <= '0;
			sr_q    <= SR_RESET;
			ier_q   <= '0;
			der_q   <= '0;
			cfgr0_q <= '0;
			cfgr1_q <= '0;
			ccr_q   <= '0;
			fcr_q   <= '0;
			tcr_q   <= TCR_RESET;
			mcfg_q  <= '0;
			mode_q  <= '0;
		end else begin
			cr_q    <= cr_d;
			sr_q    <= sr_d;
			ier_q   <= ier_d;
			der_q   <= der_d;
			cfgr0_q <= cfgr0_d;
			cfgr1_q <= cfgr1_d;
			ccr_q   <= ccr_d;
			fcr_q   <= fcr_d;
			tcr_q   <= tcr_d;
			mcfg_q  <= mcfg_d;
			mode_q  <= mode_d;
		end
	end

endmodule

>>> bench/tb_spi_master_register_block.sv
module tb_spi_master_register_block;
	import smrb_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int RX_DEPTH = 4;
	localparam int QUIET_LIMIT = 200;
	localparam int RANDOM_ACCESSES = 1400;
	localparam int MAX_GAP = 4;

	// Indexes that decode to no register at all.
	localparam logic [4:0] REG_HOLE_LOW  = 5'd10;
	localparam logic [4:0] REG_HOLE_LAST = 5'd31;

	logic      clk;
	logic      arst_n;
	logic      start;
	logic      busy;
	smrb_req_t req;
	logic      done;
	smrb_rsp_t rsp;

	// Scoreboard: mirrors the register file and receive FIFO, queues the
	// response expected for every request beat and checks each response beat.
	class spi_reg_scoreboard;
		logic [31:0] ctrl_reg, status_reg, irq_en_reg, dma_en_reg;
		logic [31:0] cfgr0_reg, cfgr1_reg, ccr_reg, fcr_reg, tcr_reg;
		logic [31:0] mcfg_reg, mode_reg, param_value;
		logic [31:0] rx_words[RX_DEPTH];
		int unsigned rx_fill;
		bit          rx_empty;
		smrb_rsp_t   pending_results[$];
		int unsigned mismatches, checked, frames_sent, rx_overflows;

		function new();
			int lg;
			lg = 0;
			while (lg < 8 && (2 << lg) <= RX_DEPTH)
				lg++;
			param_value = {8'd0, PCSNUM, 8'(lg), 8'(lg)};
			mismatches = 0;
			checked = 0;
			frames_sent = 0;
			rx_overflows = 0;
			restore_defaults();
		endfunction

		function void flush_rx();
			rx_fill = 0;
			rx_empty = 1'b1;
			status_reg[SR_RDF] = 1'b0;
		endfunction

		function void restore_defaults();
			ctrl_reg = '0;
			status_reg = SR_RESET;
			irq_en_reg = '0;
			dma_en_reg = '0;
			cfgr0_reg = '0;
			cfgr1_reg = '0;
			ccr_reg = '0;
			fcr_reg = '0;
			tcr_reg = TCR_RESET;
			mcfg_reg = '0;
			mode_reg = '0;
			flush_rx();
		endfunction

		// Apply one accepted access to the mirror and queue its response.
		function void note_access(smrb_req_t acc);
			smrb_rsp_t   want;
			logic [12:0] frame_bits;
			int unsigned nbytes;
			logic [31:0] byte_mask;
			logic [31:0] tx_word;
			want = '0;
			if (acc.op == OP_READ) begin
				case (acc.reg_req)
					REG_VERID: want.rdata = VERID_VALUE;
					REG_PARAM: want.rdata = param_value;
					REG_MCFG:  want.rdata = mcfg_reg;
					REG_MODE:  want.rdata = mode_reg;
					REG_CR:    want.rdata = ctrl_reg;
					REG_SR:    want.rdata = status_reg;
					REG_IER:   want.rdata = irq_en_reg;
					REG_DER:   want.rdata = dma_en_reg;
					REG_CFGR0: want.rdata = cfgr0_reg;
					REG_CFGR1: want.rdata = cfgr1_reg;
					REG_CCR:   want.rdata = ccr_reg;
					REG_FCR:   want.rdata = fcr_reg;
					REG_FSR:   want.rdata = {11'd0, 5'(rx_fill), 16'd0};
					REG_TCR:   want.rdata = tcr_reg;
					REG_RSR:   want.rdata = rx_empty ? RSR_RXEMPTY : 32'd0;
					REG_RDR: begin
						// A pop of an empty FIFO reads zero and changes nothing.
						if (rx_fill != 0) begin
							want.rdata = rx_words[0];
							for (int i = 1; i < rx_fill; i++)
								rx_words[i - 1] = rx_words[i];
							rx_fill--;
							if (rx_fill == 0) begin
								status_reg[SR_RDF] = 1'b0;
								rx_empty = 1'b1;
							end
						end
					end
					default: want.bad_access = 1'b1;
				endcase
			end else begin
				case (acc.reg_req)
					REG_MCFG:  mcfg_reg = acc.wdata;
					REG_MODE:  mode_reg = acc.wdata;
					REG_CR: begin
						if (acc.wdata[CR_RST]) begin
							restore_defaults();
						end else begin
							ctrl_reg = acc.wdata & ~CR_NOSTORE;
							if (acc.wdata[CR_RRF])
								flush_rx();
						end
					end
					REG_SR:    status_reg = status_reg & ~(acc.wdata & SR_W1C);
					REG_IER:   irq_en_reg = acc.wdata;
					REG_DER:   dma_en_reg = acc.wdata;
					REG_CFGR0: cfgr0_reg = acc.wdata;
					REG_CFGR1: cfgr1_reg = acc.wdata;
					REG_CCR:   ccr_reg = acc.wdata;
					REG_FCR:   fcr_reg = acc.wdata & FCR_MASK;
					REG_TCR:   tcr_reg = acc.wdata;
					REG_TDR: begin
						// Frame length is the frame size rounded up to bytes, at most four.
						frame_bits = {1'b0, tcr_reg[11:0]} + 13'd1;
						nbytes = (frame_bits + 7) / 8;
						if (!ctrl_reg[CR_MEN]) begin
							status_reg[SR_TEF] = 1'b1;
						end else begin
							if (nbytes > 4)
								nbytes = 4;
							byte_mask = (nbytes == 4) ? '1 : ((32'd1 << (8 * nbytes)) - 32'd1);
							tx_word = tcr_reg[TCR_TX_ONES] ? '1 : acc.wdata;
							want.mosi_word = tx_word & byte_mask;
							want.mosi_bytes = 3'(nbytes);
							frames_sent++;
							status_reg[SR_MBF] = 1'b0;
							status_reg[SR_TCF] = 1'b1;
							status_reg[SR_TDF] = 1'b1;
							if (!tcr_reg[TCR_RX_OFF]) begin
								if (rx_fill < RX_DEPTH) begin
									rx_words[rx_fill] = acc.miso_word & byte_mask;
									rx_fill++;
									status_reg[SR_RDF] = 1'b1;
									rx_empty = 1'b0;
								end else begin
									status_reg[SR_TEF] = 1'b1;
									rx_overflows++;
								end
							end
						end
					end
					REG_VERID, REG_PARAM, REG_FSR, REG_RSR, REG_RDR: ;
					default: want.bad_access = 1'b1;
				endcase
			end
			want.irq = |(irq_en_reg & status_reg & SR_IRQ_MASK);
			pending_results.push_back(want);
		endfunction

		function void compare_field(string fname, logic [31:0] want, logic [31:0] seen);
			if (want !== seen) begin
				$display("%0t: %s mismatch, expected %h, got %h", $time, fname, want, seen);
				mismatches++;
			end
		endfunction

		// Compare one response beat against the oldest expectation.
		function void check_result(smrb_rsp_t got);
			smrb_rsp_t want;
			if (pending_results.size() == 0) begin
				$display("%0t: response beat with nothing expected, got %h", $time, got);
				mismatches++;
				return;
			end
			want = pending_results.pop_front();
			checked++;
			compare_field("rdata", want.rdata, got.rdata);
			compare_field("mosi_word", want.mosi_word, got.mosi_word);
			compare_field("mosi_bytes", 32'(want.mosi_bytes), 32'(got.mosi_bytes));
			compare_field("irq", 32'(want.irq), 32'(got.irq));
			compare_field("bad_access", 32'(want.bad_access), 32'(got.bad_access));
		endfunction
	endclass

	spi_reg_scoreboard sb = new();
	int unsigned quiet_cycles = 0;
	int unsigned directed_count = 0;
	int unsigned random_count = 0;

	logic [4:0] readable_regs[16] = '{REG_VERID, REG_PARAM, REG_MCFG, REG_MODE, REG_CR,
		REG_SR, REG_IER, REG_DER, REG_CFGR0, REG_CFGR1, REG_CCR, REG_FCR, REG_FSR,
		REG_TCR, REG_RSR, REG_RDR};

	spi_master_register_block #(
		.RX_DEPTH(RX_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.done(done),
		.rsp(rsp)
	);

	initial clk = 1'b0;
	always begin
		#10ns clk = 1'b1;
		#10ns clk = 1'b0;
	end

	// Monitor: both beats are taken at the rising edge, from pre-edge values.
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy)
				sb.note_access(req);
			if (done)
				sb.check_result(rsp);
			if ((start && !busy) || done)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: no beat for %0d cycles", $time, QUIET_LIMIT);
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	function automatic smrb_req_t mk_access(logic op, logic [4:0] idx, logic [31:0] wdata,
		logic [31:0] miso);
		smrb_req_t acc;
		acc.op = op;
		acc.reg_req = idx;
		acc.wdata = wdata;
		acc.miso_word = miso;
		return acc;
	endfunction

	// Random access mix: mostly frames and FIFO pops, with setup writes and noise.
	function automatic smrb_req_t random_access();
		smrb_req_t   acc;
		int unsigned sel;
		acc = mk_access(OP_WRITE, REG_TDR, $urandom, $urandom);
		sel = $urandom_range(0, 99);
		if (sel < 30) begin
			acc.op = OP_WRITE;
		end else if (sel < 50) begin
			acc.op = OP_READ;
			acc.reg_req = REG_RDR;
		end else if (sel < 65) begin
			acc.op = OP_READ;
			acc.reg_req = readable_regs[$urandom_range(0, 15)];
		end else if (sel < 75) begin
			acc.reg_req = REG_TCR;
			if ($urandom_range(0, 9) < 7)
				acc.wdata[11:0] = 12'($urandom_range(0, 39));
			acc.wdata[TCR_TX_ONES] = ($urandom_range(0, 3) == 0);
			acc.wdata[TCR_RX_OFF] = ($urandom_range(0, 3) == 0);
		end else if (sel < 80) begin
			acc.reg_req = REG_CR;
			acc.wdata[CR_RST] = ($urandom_range(0, 49) == 0);
			acc.wdata[CR_MEN] = ($urandom_range(0, 9) != 0);
			acc.wdata[CR_RRF] = ($urandom_range(0, 4) == 0);
		end else if (sel < 85) begin
			acc.reg_req = REG_SR;
		end else if (sel < 90) begin
			acc.reg_req = REG_IER;
		end else begin
			acc.op = 1'($urandom_range(0, 1));
			acc.reg_req = 5'($urandom_range(0, 31));
		end
		return acc;
	endfunction

	// Offer one request beat, after an optional idle gap, and wait until it is taken.
	task automatic drive_access(input smrb_req_t acc, input int unsigned idle_pct);
		if ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			req <= mk_access(1'($urandom), 5'($urandom), $urandom, $urandom);
			repeat ($urandom_range(1, MAX_GAP)) @(posedge clk);
		end
		start <= 1'b1;
		req <= acc;
		do
			@(posedge clk);
		while (busy);
	endtask

	task automatic directed(input logic op, input logic [4:0] idx, input logic [31:0] wdata,
		input logic [31:0] miso);
		drive_access(mk_access(op, idx, wdata, miso), 0);
		directed_count++;
	endtask

	int unsigned idle_pct[4] = '{0, 70, 20, 0};

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset values, empty pop, bad and ignored accesses.
		directed(OP_READ, REG_VERID, '0, '0);
		directed(OP_READ, REG_PARAM, '0, '0);
		directed(OP_READ, REG_SR, '0, '0);
		directed(OP_READ, REG_TCR, '0, '0);
		directed(OP_READ, REG_RSR, '0, '0);
		directed(OP_READ, REG_RDR, '0, '0);
		directed(OP_READ, REG_TDR, '0, '0);
		directed(OP_READ, REG_HOLE_LAST, '1, '1);
		directed(OP_WRITE, REG_HOLE_LOW, '1, '1);
		directed(OP_WRITE, REG_VERID, '1, '1);
		// Frame with the module disabled, then enable, interrupts and a flush.
		directed(OP_WRITE, REG_TDR, 32'hdead_beef, '1);
		directed(OP_WRITE, REG_IER, '1, '0);
		directed(OP_WRITE, REG_CR, 32'hffff_fffd, '0);
		// One-byte frame, then masked four-byte frames until the FIFO overflows.
		directed(OP_WRITE, REG_TCR, '0, '0);
		directed(OP_WRITE, REG_TDR, 32'ha5a5_5a5a, 32'h1234_5678);
		directed(OP_WRITE, REG_TCR, 32'h0004_0fff, '0);
		for (int i = 0; i < 4; i++)
			directed(OP_WRITE, REG_TDR, '0, $urandom);
		directed(OP_READ, REG_FSR, '0, '0);
		directed(OP_READ, REG_RDR, '0, '0);
		directed(OP_WRITE, REG_SR, '1, '0);
		// Receive masked, FIFO control mask, then a block reset.
		directed(OP_WRITE, REG_TCR, 32'h0008_0007, '0);
		directed(OP_WRITE, REG_TDR, '1, '1);
		directed(OP_WRITE, REG_FCR, '1, '0);
		directed(OP_READ, REG_FCR, '0, '0);
		directed(OP_WRITE, REG_CR, 32'h0000_0002, '0);
		directed(OP_READ, REG_SR, '0, '0);

		// Random phases, with the sender idle rate set per phase.
		directed(OP_WRITE, REG_CR, 32'h0000_0001, '0);
		for (int ph = 0; ph < 4; ph++) begin
			for (int n = 0; n < RANDOM_ACCESSES / 4; n++) begin
				drive_access(random_access(), idle_pct[ph]);
				random_count++;
			end
		end
		start <= 1'b0;

		// Drain: the watchdog bounds this wait.
		while (sb.pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);

		$display("Covered %0d directed and %0d random accesses, %0d responses checked.",
			directed_count, random_count, sb.checked);
		$display("Sent %0d frames, saw %0d receive overflows.", sb.frames_sent,
			sb.rx_overflows);
		if (sb.mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end
endmodule

>>> sim.f
rtl/core/smrb_pkg.sv
rtl/core/smrb_rx_fifo.sv
rtl/core/smrb_regs.sv
rtl/core/spi_master_register_block.sv
bench/tb_spi_master_register_block.sv
